// File: rtl/fsc_pkg.sv
// shared constants and types for the fractional step clock
`default_nettype none

package fsc_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int TIME_W      = 64;
    localparam int ACC_W       = 64;
    localparam int PERIOD_W    = 40;
    localparam int OP_W        = 3;
    localparam int STEP_W      = 31;
    localparam int MODE_W      = 2;
    localparam int DIV_CNT_W   = 6;

    localparam logic [OP_W-1:0] OP_UPDATE = 3'd0;
    localparam logic [OP_W-1:0] OP_START  = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP   = 3'd2;
    localparam logic [OP_W-1:0] OP_PAUSE  = 3'd3;
    localparam logic [OP_W-1:0] OP_RESUME = 3'd4;
    localparam logic [OP_W-1:0] OP_REBASE = 3'd5;

    localparam logic [MODE_W-1:0] MODE_STOPPED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PLAYING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PAUSED  = 2'd2;

    typedef struct packed {
        logic item_load;
        logic exec;
        logic accum;
        logic div_init;
        logic div_step;
        logic div_end;
        logic out_load;
    } fsc_cmd_t;

    typedef struct packed {
        logic advance;
        logic step_skip;
        logic div_done;
    } fsc_status_t;

endpackage

`default_nettype wire

// File: rtl/fsc_dpath.sv
// datapath: clock state, accumulator, shift-subtract divider and result register
`default_nettype none

module fsc_dpath
    import fsc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fsc_cmd_t             cmd,
    output fsc_status_t               status,
    input  wire logic                 cfg_we,
    input  wire logic [PERIOD_W-1:0]  cfg_wdata,
    input  wire logic [OP_W-1:0]      op,
    input  wire logic [TIME_W-1:0]    now,
    output logic [STEP_W-1:0]         step_count,
    output logic [MODE_W-1:0]         run_status
);

    logic [PERIOD_W-1:0]  period_reg;
    logic [MODE_W-1:0]    mode_reg;
    logic [MODE_W-1:0]    mode_next;
    logic [TIME_W-1:0]    last_time_reg;
    logic [TIME_W-1:0]    last_time_next;
    logic [ACC_W-1:0]     acc_reg;
    logic [ACC_W-1:0]     acc_next;

    logic [OP_W-1:0]      op_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [TIME_W-1:0]    delta_reg;
    logic [STEP_W-1:0]    steps_reg;
    logic [STEP_W-1:0]    steps_next;

    logic [ACC_W-1:0]     div_q_reg;
    logic [PERIOD_W-1:0]  div_r_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [PERIOD_W:0]    div_trial;
    logic [PERIOD_W:0]    div_diff;
    logic                 div_bit;

    logic [STEP_W-1:0]    step_count_reg;
    logic [MODE_W-1:0]    run_status_reg;

    assign status.advance   = (op_reg == OP_UPDATE) && (mode_reg == MODE_PLAYING);
    assign status.step_skip = (period_reg == '0) || (acc_reg < {{(ACC_W-PERIOD_W){1'b0}}, period_reg});
    assign status.div_done  = (div_cnt_reg == {DIV_CNT_W{1'b1}});

    // one restoring step per cycle, quotient bits shift in behind the dividend
    assign div_trial = {div_r_reg, div_q_reg[ACC_W-1]};
    assign div_diff  = div_trial - {1'b0, period_reg};
    assign div_bit   = (div_trial >= {1'b0, period_reg});

    always_comb
    begin
        mode_next      = mode_reg;
        last_time_next = last_time_reg;
        acc_next       = acc_reg;
        steps_next     = steps_reg;
        if (cmd.exec)
        begin
            steps_next = '0;
            case (op_reg)
                OP_UPDATE:
                begin
                    if (mode_reg == MODE_PLAYING)
                    begin
                        last_time_next = now_reg;
                    end
                end
                OP_START:
                begin
                    mode_next      = MODE_PLAYING;
                    last_time_next = now_reg;
                    acc_next       = {{(ACC_W-PERIOD_W){1'b0}}, period_reg};
                end
                OP_STOP:
                begin
                    mode_next = MODE_STOPPED;
                end
                OP_PAUSE:
                begin
                    mode_next = MODE_PAUSED;
                end
                OP_RESUME:
                begin
                    if (mode_reg == MODE_PAUSED)
                    begin
                        mode_next      = MODE_PLAYING;
                        last_time_next = now_reg;
                    end
                end
                OP_REBASE:
                begin
                    last_time_next = now_reg;
                    acc_next       = '0;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
        if (cmd.accum)
        begin
            acc_next = acc_reg + (delta_reg << FRAC_BITS);
        end
        if (cmd.div_end)
        begin
            acc_next = {{(ACC_W-PERIOD_W){1'b0}}, div_r_reg};
            // saturate the quotient to the step count range
            if (div_q_reg[ACC_W-1:STEP_W] != '0)
            begin
                steps_next = {STEP_W{1'b1}};
            end
            else
            begin
                steps_next = div_q_reg[STEP_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= '0;
            mode_reg      <= MODE_STOPPED;
            last_time_reg <= '0;
            acc_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                period_reg <= cfg_wdata;
            end
            mode_reg      <= mode_next;
            last_time_reg <= last_time_next;
            acc_reg       <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            op_reg  <= op;
            now_reg <= now;
        end
        if (cmd.exec)
        begin
            delta_reg <= now_reg - last_time_reg;
        end
        steps_reg <= steps_next;
        if (cmd.div_init)
        begin
            div_q_reg   <= acc_reg;
            div_r_reg   <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_q_reg   <= {div_q_reg[ACC_W-2:0], div_bit};
            div_r_reg   <= div_bit ? div_diff[PERIOD_W-1:0] : div_trial[PERIOD_W-1:0];
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (cmd.out_load)
        begin
            step_count_reg <= steps_reg;
            run_status_reg <= mode_reg;
        end
    end

    assign step_count = step_count_reg;
    assign run_status = run_status_reg;

endmodule

`default_nettype wire

// File: rtl/fsc_ctrl.sv
// controller: sequences one word through execute, accumulate, divide and write-out
`default_nettype none

module fsc_ctrl
    import fsc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  wire logic        out_stall,
    output fsc_cmd_t         cmd,
    input  wire fsc_status_t status
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_ACCUM = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DEND  = 3'd5;
    localparam logic [2:0] ST_WB    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = status.advance ? ST_ACCUM : ST_WB;
            end
            ST_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.step_skip)
                begin
                    state_next = ST_WB;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_DEND;
                end
            end
            ST_DEND:
            begin
                cmd.div_end = 1'b1;
                state_next  = ST_WB;
            end
            ST_WB:
            begin
                // hold the word until the output register is free
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/fractional_step_clock.sv
// top level of the fractional step clock
//
// input channel: in_valid / in_stall with op and now. a word is taken when
// in_valid is high and in_stall is low; in_stall is high while a word is
// being worked on. each input word gives exactly one output word on
// out_valid / out_stall with step_count and run_status.
// control ops and updates while not playing go from execute straight to
// write-out; an update that fires no step goes through execute, accumulate
// and check; an update that fires also runs the shift-subtract divide of the
// accumulator by step_period and a divide-end step before write-out.
// one word is in flight at a time: the next word is taken only after the last
// is loaded into the output register. step_period is written through cfg_we /
// cfg_wdata while the block is idle; the user is bound to this, the block
// itself does not enforce it. reset clears the mode to stopped and last time,
// accumulator and period to zero; no word is pending after reset.
// a stalled output word holds; the next input word may be taken and worked
// on meanwhile, and its result waits until the output register is free.
`default_nettype none

module fractional_step_clock
    import fsc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [PERIOD_W-1:0]  cfg_wdata,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [OP_W-1:0]      op,
    input  wire logic [TIME_W-1:0]    now,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [STEP_W-1:0]         step_count,
    output logic [MODE_W-1:0]         run_status
);

    fsc_cmd_t    cmd;
    fsc_status_t status;

    fsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    fsc_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .op         (op),
        .now        (now),
        .step_count (step_count),
        .run_status (run_status)
    );

endmodule

`default_nettype wire

// File: test/tb_fractional_step_clock.sv
// testbench for the fractional step clock: shadow state, scoreboard and stimulus
`timescale 1ns / 100ps

import fsc_pkg::*;

class step_clock_shadow;
    logic [PERIOD_W-1:0] period = '0;
    logic [MODE_W-1:0]   mode = MODE_STOPPED;
    logic [TIME_W-1:0]   last_t = '0;
    logic [ACC_W-1:0]    acc = '0;
    logic [STEP_W-1:0]   want_steps[$];
    logic [MODE_W-1:0]   want_status[$];
    int                  fails = 0;

    // advance the shadow state by one accepted word and queue its result
    function void take_word(input logic [OP_W-1:0] code, input logic [TIME_W-1:0] t);
        logic [ACC_W-1:0]  div;
        logic [ACC_W-1:0]  quot;
        logic [STEP_W-1:0] steps;
        div = {{(ACC_W-PERIOD_W){1'b0}}, period};
        steps = '0;
        case (code)
            OP_UPDATE:
                if (mode == MODE_PLAYING) begin
                    acc = acc + ((t - last_t) << FRAC_BITS);
                    last_t = t;
                    if (period != '0 && acc >= div) begin
                        quot = acc / div;
                        acc = acc % div;
                        steps = (quot > 64'h7FFF_FFFF) ? {STEP_W{1'b1}} : quot[STEP_W-1:0];
                    end
                end
            OP_START:
            begin
                mode = MODE_PLAYING;
                last_t = t;
                acc = div;
            end
            OP_STOP:   mode = MODE_STOPPED;
            OP_PAUSE:  mode = MODE_PAUSED;
            OP_RESUME:
                if (mode == MODE_PAUSED) begin
                    mode = MODE_PLAYING;
                    last_t = t;
                end
            OP_REBASE:
            begin
                last_t = t;
                acc = '0;
            end
            default: ;
        endcase
        want_steps.push_back(steps);
        want_status.push_back(mode);
    endfunction

    function void check_word(input logic [STEP_W-1:0] steps, input logic [MODE_W-1:0] status);
        logic [STEP_W-1:0] e_steps;
        logic [MODE_W-1:0] e_status;
        if (want_steps.size() == 0) begin
            $display("%0t: unexpected output word step_count %0d run_status %0d",
                     $time, steps, status);
            fails++;
            return;
        end
        e_steps = want_steps.pop_front();
        e_status = want_status.pop_front();
        if (steps !== e_steps) begin
            $display("%0t: step_count expected %0d, got %0d", $time, e_steps, steps);
            fails++;
        end
        if (status !== e_status) begin
            $display("%0t: run_status expected %0d, got %0d", $time, e_status, status);
            fails++;
        end
    endfunction

    function int pending();
        return want_steps.size();
    endfunction
endclass

module tb_fractional_step_clock;

    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
    localparam int              NUM_PHASES = 7;
    localparam int              PHASE_WORDS = 220;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [PERIOD_W-1:0] cfg_wdata;
    logic                in_valid;
    logic                in_stall;
    logic [OP_W-1:0]     op;
    logic [TIME_W-1:0]   now;
    logic                out_valid;
    logic                out_stall;
    logic [STEP_W-1:0]   step_count;
    logic [MODE_W-1:0]   run_status;

    bit                  no_idle;
    step_clock_shadow    shadow;

    fractional_step_clock dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .now        (now),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .step_count (step_count),
        .run_status (run_status)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // returns once in_stall is low again, with in_valid still high; the next call lowers or reloads it
    task automatic send_word(input logic [OP_W-1:0] code, input logic [TIME_W-1:0] t);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= code;
        now <= t;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        shadow.take_word(code, t);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (shadow.pending() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic load_period(input logic [PERIOD_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow.period = value;
    endtask

    // output side: random stall before each word
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = no_idle ? 0 : $urandom_range(0, 14);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                shadow.check_word(step_count, run_status);
        end
    end

    initial
    begin
        logic [PERIOD_W-1:0] pv;
        logic [63:0]         r64;
        logic [63:0]         step_ticks;
        logic [63:0]         cur_t;
        logic [OP_W-1:0]     code;
        int                  r;

        shadow = new;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        op = OP_UPDATE;
        now = '0;
        out_stall = 1'b0;
        no_idle = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero period out of reset: status moves, no stepping
        send_word(OP_UPDATE, 64'd5);
        send_word(OP_PAUSE, 64'd10);
        send_word(OP_RESUME, 64'd20);
        send_word(OP_UPDATE, 64'd100);
        send_word(OP_SPARE_A, 64'd150);
        send_word(OP_SPARE_B, 64'd160);
        send_word(OP_START, 64'd200);
        send_word(OP_UPDATE, 64'd300);
        send_word(OP_STOP, 64'd300);
        send_word(OP_RESUME, 64'd301);
        wait_drain();

        // three ticks per step
        load_period(40'd768);
        send_word(OP_START, 64'd1000);
        send_word(OP_UPDATE, 64'd1000);
        send_word(OP_UPDATE, 64'd1010);
        send_word(OP_REBASE, 64'd1020);
        send_word(OP_UPDATE, 64'd1023);
        send_word(OP_PAUSE, 64'd1030);
        send_word(OP_UPDATE, 64'd2000);
        send_word(OP_RESUME, 64'd2000);
        send_word(OP_UPDATE, 64'd2003);
        wait_drain();

        // smallest period: saturation and time wrap
        load_period(40'd1);
        send_word(OP_START, 64'd0);
        send_word(OP_UPDATE, 64'h0000_0100_0000_0000);
        send_word(OP_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(OP_UPDATE, 64'd0);
        wait_drain();

        load_period({PERIOD_W{1'b1}});
        send_word(OP_START, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(OP_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(OP_UPDATE, 64'h0000_0000_FFFF_FFFF);
        send_word(OP_STOP, 64'd0);

        cur_t = rand64();
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            r64 = rand64();
            case (ph)
                0: pv = '0;
                1: pv = 40'd1;
                2: pv = {PERIOD_W{1'b1}};
                3: pv = PERIOD_W'($urandom_range(1, 4096));
                4: pv = 40'd256 * $urandom_range(1, 100);
                5: pv = r64[PERIOD_W-1:0];
                default: pv = r64[PERIOD_W-1:0] >> $urandom_range(0, 30);
            endcase
            wait_drain();
            load_period(pv);
            step_ticks = ({24'd0, pv} >> FRAC_BITS) + 64'd1;

            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                if (i % 50 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 199) == 0)
                    wait_drain();

                r = $urandom_range(0, 99);
                if (r < 4)
                begin
                    // noise: any code, any time
                    code = OP_W'($urandom_range(0, 7));
                    send_word(code, rand64());
                    continue;
                end
                if (shadow.mode == MODE_STOPPED && r < 60)
                    code = OP_START;
                else if (shadow.mode == MODE_PAUSED && r < 60)
                    code = OP_RESUME;
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 70)      code = OP_UPDATE;
                    else if (r < 75) code = OP_START;
                    else if (r < 80) code = OP_STOP;
                    else if (r < 88) code = OP_PAUSE;
                    else if (r < 95) code = OP_RESUME;
                    else             code = OP_REBASE;
                end

                r = $urandom_range(0, 99);
                if (r < 60)
                    cur_t = cur_t + $urandom_range(0, 4) * step_ticks + rand64() % step_ticks;
                else if (r < 80)
                    cur_t = cur_t + $urandom_range(0, 1000);
                else if (r < 92)
                    cur_t = cur_t + (rand64() >> $urandom_range(8, 40));
                else
                    cur_t = rand64();
                send_word(code, cur_t);
            end
        end

        no_idle = 1'b0;
        wait_drain();
        repeat (80) @(posedge clk);
        if (shadow.fails == 0 && shadow.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
